/* src/sgl_pkg.sv */
// sgl_pkg: shared constants, log2 depth table and control types for shadow_gamma_lift
// depends on nothing; imported by every module of the block
package sgl_pkg;

  localparam int KNEE   = 114;
  localparam int NSTAGE = 8;     // prep stage plus one stage per search bit
  localparam int SBITS  = 7;     // bits of the result search (64 down to 1)

  typedef logic [18:0] lg_t;
  typedef lg_t lg_tab_t [128];

  typedef struct packed {
    logic [NSTAGE-1:0] load;     // stage register takes a new word
  } sgl_ctl_t;

  // log2 in unsigned q16 by repeated squaring of a q30 mantissa
  function automatic lg_t lg_q16(input int x);
    logic [63:0] m;
    int          n;
    lg_t         res;
    n   = 0;
    res = '0;
    if (x == 0) return '0;
    while (n < 7 && (x >> (n + 1)) != 0) n++;
    m   = 64'(x) << (30 - n);
    res = 19'(n) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m      = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  // depth below the knee, lg(knee) - lg(x), for x up to 127
  function automatic lg_tab_t depth_tab();
    lg_tab_t t;
    for (int x = 0; x < 128; x++) begin
      t[x] = lg_q16(KNEE) - lg_q16(x);
    end
    return t;
  endfunction

  localparam lg_tab_t DEPTH = depth_tab();

endpackage

/* src/sgl_ctrl.sv */
// sgl_ctrl: valid bits and per-stage load enables of the lane pipeline
// depends on sgl_pkg; drives the shared control struct of the lanes
module sgl_ctrl import sgl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output sgl_ctl_t ctl
);

  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] en;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign ctl.load  = en;
  assign in_ready  = en[0];
  assign out_valid = v[NSTAGE-1];

  // valid bits follow the words down the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !v[NSTAGE-1] |-> in_ready)
    else $error("input stalled with empty output");
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted word lost at first stage");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !v[NSTAGE-2] |=> !out_valid)
    else $error("output word repeated");
`endif

endmodule

/* src/sgl_lane.sv */
// sgl_lane: one color channel, prep stage then one search bit per stage
// depends on sgl_pkg (depth table, knee, control struct)
module sgl_lane import sgl_pkg::*; (
  input  logic       clk,
  input  sgl_ctl_t   ctl,
  input  logic [7:0] c,
  input  logic       g_zero,
  input  logic [6:0] num,
  input  logic       big,
  output logic [7:0] res
);

  logic        fix [NSTAGE];
  logic [7:0]  val [NSTAGE];
  logic [25:0] x   [NSTAGE];
  logic        bg  [NSTAGE];

  logic        pass0;
  logic        fix0;
  logic [7:0]  val0;

  // prep: special cases and scaled target
  always_comb begin
    pass0 = g_zero || (c >= 8'(KNEE));
    fix0  = pass0 || (c == 8'd0);
    if (pass0) begin
      val0 = c;
    end else if (c == 8'd0 && num == 7'd0) begin
      val0 = 8'(KNEE);
    end else begin
      val0 = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      fix[0] <= fix0;
      val[0] <= val0;
      x[0]   <= 26'(DEPTH[c[6:0]]) * 26'(num);
      bg[0]  <= big;
    end
  end

  // search stages, most significant bit first
  for (genvar k = 1; k < NSTAGE; k++) begin : g_bit
    localparam int B = SBITS - k;
    logic [7:0]  cand;
    logic [26:0] dd;
    logic [26:0] prod;
    logic        take;

    always_comb begin
      cand = {1'b0, val[k-1][6:0] | 7'(1 << B)};
      dd   = 27'(DEPTH[cand[6:0]]) + 27'd1;
      prod = bg[k-1] ? 27'(dd * 27'd100) : 27'(dd * 27'd10);
      take = !fix[k-1] && (cand <= 8'(KNEE)) && (prod > 27'(x[k-1]));
    end

    always_ff @(posedge clk) begin
      if (ctl.load[k]) begin
        fix[k] <= fix[k-1];
        val[k] <= take ? cand : val[k-1];
        x[k]   <= x[k-1];
        bg[k]  <= bg[k-1];
      end
    end
  end

  assign res = val[NSTAGE-1];

endmodule

/* src/shadow_gamma_lift.sv */
// shadow_gamma_lift: shadow range gamma lift of one rgb pixel per word
// depends on sgl_pkg, sgl_ctrl, sgl_lane
//
// Usage: input channel in_valid/in_ready carries blue_in, green_in, red_in;
// output channel out_valid/out_ready carries blue_out, green_out, red_out.
// The strength register is written through wr_en/wr_data; the written
// byte is taken as signed and saturated to -100..100. Write it only while
// the pipeline is empty.
// A word passes one prep stage that forms the scaled log2 target, then
// seven stages that each decide one bit of the result by a depth table
// lookup and compare. Three lanes, one per channel, run side by side, so
// a pixel is taken every cycle while the receiver keeps out_ready high.
// When the receiver stalls, words pack into empty stages and in_ready
// drops only once all eight stages hold a word. Reset empties the
// pipeline and sets strength to 0 (pixels pass unchanged).
module shadow_gamma_lift import sgl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] blue_in,
  input  logic [7:0] green_in,
  input  logic [7:0] red_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] blue_out,
  output logic [7:0] green_out,
  output logic [7:0] red_out,
  input  logic       wr_en,
  input  logic signed [7:0] wr_data
);

  logic signed [7:0] strength;
  logic signed [7:0] strength_next;
  logic              g_zero;
  logic [6:0]        num;
  logic              big;
  sgl_ctl_t          ctl;

  // saturate register writes
  always_comb begin
    if (wr_data > 8'sd100) begin
      strength_next = 8'sd100;
    end else if (wr_data < -8'sd100) begin
      strength_next = -8'sd100;
    end else begin
      strength_next = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= '0;
    end else if (wr_en) begin
      strength <= strength_next;
    end
  end

  // exponent as num/den, den 100 for lift and 10 for deepen
  always_comb begin
    g_zero = (strength == 8'sd0);
    big    = !strength[7];
    if (strength[7]) begin
      num = 7'(8'sd10 - strength);
    end else begin
      num = 7'(8'sd100 - strength);
    end
  end

  sgl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  sgl_lane u_blue (
    .clk (clk), .ctl (ctl), .c (blue_in), .g_zero (g_zero),
    .num (num), .big (big), .res (blue_out)
  );

  sgl_lane u_green (
    .clk (clk), .ctl (ctl), .c (green_in), .g_zero (g_zero),
    .num (num), .big (big), .res (green_out)
  );

  sgl_lane u_red (
    .clk (clk), .ctl (ctl), .c (red_in), .g_zero (g_zero),
    .num (num), .big (big), .res (red_out)
  );

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for shadow_gamma_lift, rgb shadow gamma lift
// depends on src/sgl_pkg.sv and src/shadow_gamma_lift.sv
`timescale 1ns / 1ps

module tb_top;
  import sgl_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] blue_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] red_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       wr_en = 1'b0;
  logic signed [7:0] wr_data = '0;

  pixel_t lifted_q[$];
  int     strength_now = 0;
  int     mismatches = 0;
  bit     idle_on = 1'b0;
  int     stall_left = 0;

  shadow_gamma_lift u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .blue_in(blue_in), .green_in(green_in), .red_in(red_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .blue_out(blue_out), .green_out(green_out), .red_out(red_out),
    .wr_en(wr_en), .wr_data(wr_data)
  );

  always #1 clk = ~clk;

  // log2 in q16 by squaring a q30 mantissa
  function automatic longint log2_q16(int x);
    int      n;
    longint  res;
    bit [63:0] m;
    n = 0;
    if (x == 0) return 0;
    while (n < 7 && (x >> (n + 1)) != 0) n++;
    m = 64'(x) << (30 - n);
    res = longint'(n) << 16;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        res = res | (longint'(1) << i);
      end
    end
    return res;
  endfunction

  function automatic longint knee_depth(int x);
    return log2_q16(KNEE) - log2_q16(x);
  endfunction

  // one channel through the shadow curve
  function automatic logic [7:0] lift_channel(logic [7:0] c, int g);
    longint num, den, tgt;
    int     acc, cand;
    if (g == 0 || c >= KNEE) return c;
    if (g > 0) begin
      num = 100 - g;
      den = 100;
    end else begin
      num = 10 - g;
      den = 10;
    end
    if (c == 0) return (num == 0) ? 8'(KNEE) : 8'd0;
    tgt = (knee_depth(c) * num) / den;
    acc = 0;
    for (int bt = 64; bt != 0; bt = bt >> 1) begin
      cand = acc | bt;
      if (cand <= KNEE && knee_depth(cand) >= tgt) acc = cand;
    end
    return 8'(acc);
  endfunction

  // result checker with random receiver stalls
  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{b: blue_out, g: green_out, r: red_out};
        if (lifted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word b=%0d g=%0d r=%0d", got.b, got.g, got.r);
        end else begin
          want = lifted_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp b=%0d g=%0d r=%0d got b=%0d g=%0d r=%0d",
                       want.b, want.g, want.r, got.b, got.g, got.r);
          end
        end
      end
      if (stall_left > 0) stall_left <= stall_left - 1;
      else if (idle_on && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 14);
      out_ready <= !(stall_left > 1 || (stall_left == 0 && 1'b0)) ? 1'b1 : 1'b0;
    end
  end

  // send one pixel word and record its prediction on acceptance
  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    blue_in  <= b;
    green_in <= g;
    red_in   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lifted_q.push_back('{b: lift_channel(b, strength_now),
                         g: lift_channel(g, strength_now),
                         r: lift_channel(r, strength_now)});
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (lifted_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // strength write while the pipeline is empty
  task automatic set_strength(logic [7:0] v);
    int s;
    drain_all();
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en <= 1'b0;
    s = int'(v);
    if (s >= 128) s -= 256;
    if (s > 100) s = 100;
    if (s < -100) s = -100;
    strength_now = s;
  endtask

  task automatic test_reset_bypass();
    send_pixel(8'd0, 8'd113, 8'd255);
    send_pixel(8'd1, 8'd114, 8'd57);
  endtask

  task automatic test_directed_extremes();
    logic [7:0] codes[8] = '{8'd100, 8'h9c, 8'd1, 8'hff, 8'd127, 8'h80, 8'd101, 8'h00};
    foreach (codes[k]) begin
      set_strength(codes[k]);
      send_pixel(8'd0, 8'd1, 8'd113);
      send_pixel(8'd114, 8'd255, 8'd56);
    end
  endtask

  task automatic test_random_phases();
    int cnt;
    idle_on = 1'b1;
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: set_strength(8'($urandom_range(0, 255)));
        1: set_strength(8'(100 - $urandom_range(0, 200)));
        2: set_strength($urandom_range(0, 1) ? 8'd100 : 8'h9c);
        default: set_strength(8'($urandom_range(1, 100)));
      endcase
      cnt = 100;
      for (int i = 0; i < cnt; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        else
          send_pixel(8'($urandom_range(0, 113)), 8'($urandom_range(0, 113)),
                     8'($urandom_range(0, 113)));
        if (ph == 5 && i == 50) drain_all();
      end
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    set_strength(8'($urandom_range(0, 255)));
    for (int i = 0; i < 60; i++)
      send_pixel(8'($urandom), 8'($urandom_range(0, 113)), 8'($urandom));
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    out_ready <= 1'b1;
    @(posedge clk);
    test_reset_bypass();
    test_directed_extremes();
    test_random_phases();
    test_full_rate();
    while (lifted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #800000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
